@@ src/cabpw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabpw_pkg
// Shared types, register indexes and helpers for the clipped alpha-blend
// pixel writer.
// ----------------------------------------------------------------------------
package cabpw_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
    localparam logic [7:0]  FULL_SCALE   = 8'd255;

    // Reciprocal of 255 for a 16-bit dividend: q = (v * 0x8081) >> 23
    localparam logic [15:0] RECIP_255 = 16'h8081;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 4'd0,
        CFG_FRAME_HEIGHT = 4'd1,
        CFG_CLIP_LEFT    = 4'd2,
        CFG_CLIP_TOP     = 4'd3,
        CFG_CLIP_WIDTH   = 4'd4,
        CFG_CLIP_HEIGHT  = 4'd5,
        CFG_CLIP_ON      = 4'd6,
        CFG_GLOBAL_ALPHA = 4'd7
    } cfg_idx_t;

    // Configuration register file contents
    typedef struct packed {
        logic [12:0]        frame_width;
        logic [12:0]        frame_height;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_width;
        logic signed [15:0] clip_height;
        logic               clip_on;
        logic [7:0]         global_alpha;
    } cfg_t;

    // Per-pixel payload carried down the pipeline
    typedef struct packed {
        logic               ok;
        logic               zero;
        logic               full;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        src;
        logic [31:0]        dst;
    } pix_t;

    // Exact floor(v / 255) for any v up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [31:0] prod;
        prod = v * RECIP_255;
        return prod[30:23];
    endfunction

endpackage

@@ src/cabpw_clip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabpw_clip
// Framebuffer bounds and clip window test, one registered stage.
// ----------------------------------------------------------------------------
module cabpw_clip (
    input  logic                clk,
    input  cabpw_pkg::cfg_t     cfg,
    input  logic signed [15:0]  x,
    input  logic signed [15:0]  y,
    output logic                ok
);
    import cabpw_pkg::*;

    logic               in_frame;
    logic               in_clip;
    logic signed [16:0] x_ext;
    logic signed [16:0] y_ext;
    logic signed [16:0] left_ext;
    logic signed [16:0] top_ext;
    logic signed [16:0] right_ext;
    logic signed [16:0] bottom_ext;
    logic               ok_reg;
    logic               ok_next;

    // Frame bounds: non-negative and below the frame size
    always_comb
    begin
        in_frame = !x[15] && !y[15]
                && ({1'b0, x[14:0]} < {3'b000, cfg.frame_width})
                && ({1'b0, y[14:0]} < {3'b000, cfg.frame_height});
    end

    // Clip window edges, exact in 17 bits
    always_comb
    begin
        x_ext      = {x[15], x};
        y_ext      = {y[15], y};
        left_ext   = {cfg.clip_left[15], cfg.clip_left};
        top_ext    = {cfg.clip_top[15], cfg.clip_top};
        right_ext  = left_ext + {cfg.clip_width[15], cfg.clip_width};
        bottom_ext = top_ext + {cfg.clip_height[15], cfg.clip_height};
        in_clip    = (x_ext >= left_ext) && (x_ext < right_ext)
                  && (y_ext >= top_ext) && (y_ext < bottom_ext);
        ok_next    = in_frame && (!cfg.clip_on || in_clip);
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
    end

    assign ok = ok_reg;

endmodule

@@ src/cabpw_alpha.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabpw_alpha
// Effective alpha: source alpha times global alpha, divided by 255.
// Two stages: multiply, then reciprocal multiply.
// ----------------------------------------------------------------------------
module cabpw_alpha (
    input  logic        clk,
    input  logic [7:0]  src_alpha,
    input  logic [7:0]  global_alpha,
    output logic [7:0]  alpha
);
    import cabpw_pkg::*;

    logic [15:0] prod_reg;
    logic [15:0] prod_next;
    logic [7:0]  alpha_reg;
    logic [7:0]  alpha_next;

    always_comb
    begin
        prod_next  = src_alpha * global_alpha;
        alpha_next = div255(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        alpha_reg <= alpha_next;
    end

    assign alpha = alpha_reg;

endmodule

@@ src/cabpw_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabpw_mix
// One color channel: d + (s - d) * a / 255, truncating toward zero.
// Three stages: difference, product, scaled magnitude; final add is
// combinational on the output.
// ----------------------------------------------------------------------------
module cabpw_mix (
    input  logic        clk,
    input  logic [7:0]  d,
    input  logic [7:0]  s,
    input  logic [7:0]  alpha,
    output logic [7:0]  mixed
);
    import cabpw_pkg::*;

    logic signed [8:0]  diff_reg;
    logic signed [8:0]  diff_next;
    logic [7:0]         d2_reg;
    logic signed [16:0] prod_reg;
    logic signed [16:0] prod_next;
    logic signed [17:0] prod_full;
    logic [7:0]         d3_reg;
    logic [15:0]        mag;
    logic [7:0]         quot_reg;
    logic [7:0]         quot_next;
    logic               neg_reg;
    logic [7:0]         d4_reg;

    // Signed difference, product and scaled magnitude
    always_comb
    begin
        diff_next = $signed({1'b0, s}) - $signed({1'b0, d});
        prod_full = diff_reg * $signed({1'b0, alpha});
        prod_next = prod_full[16:0];
        mag       = prod_reg[16] ? 16'((-prod_reg)) : prod_reg[15:0];
        quot_next = div255(mag);
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        d2_reg   <= d;
        prod_reg <= prod_next;
        d3_reg   <= d2_reg;
        quot_reg <= quot_next;
        neg_reg  <= prod_reg[16];
        d4_reg   <= d3_reg;
    end

    // Apply the truncated quotient with its sign
    assign mixed = neg_reg ? (d4_reg - quot_reg) : (d4_reg + quot_reg);

endmodule

@@ src/clipped_alpha_blend_pixel_write.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_alpha_blend_pixel_write
// Clip-tested source-over ARGB8888 blend of one pixel write per clock.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock in which start is high (busy is always
// low) and its result appears on the registered output ports with done
// high for that one cycle. The five-stage pipeline (bounds and alpha
// product, alpha scaling, channel product, channel scaling, final select)
// sets the rate of one pixel per clock.
// Results are not held: the receiver takes each one in its done cycle.
// Configuration writes take effect on the next clock and should be made
// only while no pixel is in flight.
// ----------------------------------------------------------------------------
module clipped_alpha_blend_pixel_write (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [15:0]                   pixel_x,
    input  logic signed [15:0]                   pixel_y,
    input  logic [31:0]                          source_color,
    input  logic [31:0]                          dest_color,
    output logic                                 done,
    output logic                                 write_enable,
    output logic signed [15:0]                   out_x,
    output logic signed [15:0]                   out_y,
    output logic [31:0]                          blended_color,
    input  logic                                 cfg_we,
    input  logic [cabpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cabpw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cabpw_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    pix_t        stg_reg [1:4];
    pix_t        stg_next [1:4];
    logic [4:1]  vld_reg;
    logic [4:1]  vld_next;
    logic        clip_ok;
    logic [7:0]  alpha;
    logic [7:0]  mix_r;
    logic [7:0]  mix_g;
    logic [7:0]  mix_b;
    logic        done_reg;
    logic        we_reg;
    logic        we_next;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic [31:0] color_reg;
    logic [31:0] color_next;

    assign busy = 1'b0;

    // Configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[12:0];
                CFG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[12:0];
                CFG_CLIP_LEFT:    cfg_next.clip_left    = cfg_data;
                CFG_CLIP_TOP:     cfg_next.clip_top     = cfg_data;
                CFG_CLIP_WIDTH:   cfg_next.clip_width   = cfg_data;
                CFG_CLIP_HEIGHT:  cfg_next.clip_height  = cfg_data;
                CFG_CLIP_ON:      cfg_next.clip_on      = cfg_data[0];
                CFG_GLOBAL_ALPHA: cfg_next.global_alpha = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{frame_width:  13'd0,
                         frame_height: 13'd0,
                         clip_left:    16'sd0,
                         clip_top:     16'sd0,
                         clip_width:   16'sd0,
                         clip_height:  16'sd0,
                         clip_on:      1'b0,
                         global_alpha: FULL_SCALE};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Bounds and clip test, valid at stage 1
    cabpw_clip u_clip (
        .clk (clk),
        .cfg (cfg_reg),
        .x   (pixel_x),
        .y   (pixel_y),
        .ok  (clip_ok)
    );

    // Effective alpha, valid at stage 2
    cabpw_alpha u_alpha (
        .clk          (clk),
        .src_alpha    (source_color[31:24]),
        .global_alpha (cfg_reg.global_alpha),
        .alpha        (alpha)
    );

    // Channel mixers, results valid after stage 4
    cabpw_mix u_mix_r (
        .clk   (clk),
        .d     (stg_reg[1].dst[23:16]),
        .s     (stg_reg[1].src[23:16]),
        .alpha (alpha),
        .mixed (mix_r)
    );

    cabpw_mix u_mix_g (
        .clk   (clk),
        .d     (stg_reg[1].dst[15:8]),
        .s     (stg_reg[1].src[15:8]),
        .alpha (alpha),
        .mixed (mix_g)
    );

    cabpw_mix u_mix_b (
        .clk   (clk),
        .d     (stg_reg[1].dst[7:0]),
        .s     (stg_reg[1].src[7:0]),
        .alpha (alpha),
        .mixed (mix_b)
    );

    // Payload pipeline; flags join at the stage where they are known
    always_comb
    begin
        stg_next[1]      = '0;
        stg_next[1].x    = pixel_x;
        stg_next[1].y    = pixel_y;
        stg_next[1].src  = source_color;
        stg_next[1].dst  = dest_color;
        stg_next[2]      = stg_reg[1];
        stg_next[2].ok   = clip_ok;
        stg_next[3]      = stg_reg[2];
        stg_next[3].zero = (alpha == 8'd0);
        stg_next[3].full = (alpha == FULL_SCALE);
        stg_next[4]      = stg_reg[3];
        vld_next         = {vld_reg[3:1], start && !busy};
    end

    always_ff @(posedge clk)
    begin
        stg_reg[1] <= stg_next[1];
        stg_reg[2] <= stg_next[2];
        stg_reg[3] <= stg_next[3];
        stg_reg[4] <= stg_next[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Final color select
    always_comb
    begin
        we_next = stg_reg[4].ok;
        if (!stg_reg[4].ok || stg_reg[4].zero)
        begin
            color_next = stg_reg[4].dst;
        end
        else if (stg_reg[4].full)
        begin
            color_next = stg_reg[4].src;
        end
        else
        begin
            color_next = ALPHA_OPAQUE | {8'h00, mix_r, mix_g, mix_b};
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        we_reg    <= we_next;
        x_reg     <= stg_reg[4].x;
        y_reg     <= stg_reg[4].y;
        color_reg <= color_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[4];
        end
    end

    assign done          = done_reg;
    assign write_enable  = we_reg;
    assign out_x         = x_reg;
    assign out_y         = y_reg;
    assign blended_color = color_reg;

    // Every accepted pixel comes out with a done strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("accepted pixel did not produce a result");

    // Coordinates line up with the pixel that produced the result
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_x == $past(pixel_x, 5)) && (out_y == $past(pixel_y, 5)))
        else $error("echoed coordinates misaligned");

    // Suppressed write keeps the destination color
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !write_enable) |-> (blended_color == $past(dest_color, 5)))
        else $error("suppressed write altered the color");

    // An enabled write never has negative coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && write_enable) |-> (!out_x[15] && !out_y[15]))
        else $error("write enabled outside the framebuffer");

endmodule

@@ dv/tb_clipped_alpha_blend_pixel_write.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clipped_alpha_blend_pixel_write
// Self-checking bench for the clipped alpha-blend pixel writer.
// ----------------------------------------------------------------------------
// Every pixel transfer is scored against a blend predictor that keeps its own
// copy of the register file. Directed tests cover reset state, frame bounds,
// the clip window with its edge sums, the blend rules and unused register
// indexes. Random traffic then runs over several register settings with
// varying sender gaps. Registers are rewritten only once the pipe has drained.
// ----------------------------------------------------------------------------
module tb_clipped_alpha_blend_pixel_write;

    import cabpw_pkg::*;

    localparam int RESET_CYCLES    = 5;
    localparam int PIPE_LATENCY    = 5;
    localparam int SETTLE_CYCLES   = 2 * PIPE_LATENCY;
    localparam int STALL_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 215;

    // first register index past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_GLOBAL_ALPHA + 1'b1;

    typedef struct packed {
        logic               we;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        color;
    } pixel_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [15:0]       pixel_x = '0;
    logic signed [15:0]       pixel_y = '0;
    logic [31:0]              source_color = '0;
    logic [31:0]              dest_color = '0;
    logic                     done;
    logic                     write_enable;
    logic signed [15:0]       out_x;
    logic signed [15:0]       out_y;
    logic [31:0]              blended_color;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    cfg_t          model_cfg;
    pixel_result_t pending_results[$];
    pixel_result_t got_result;
    pixel_result_t want_result;

    int gap_pct = 0;
    int n_errors = 0;
    int n_pixels = 0;
    int n_written = 0;
    int n_suppressed = 0;
    int n_settings = 0;
    int stall_cycles = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    clipped_alpha_blend_pixel_write DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .source_color  (source_color),
        .dest_color    (dest_color),
        .done          (done),
        .write_enable  (write_enable),
        .out_x         (out_x),
        .out_y         (out_y),
        .blended_color (blended_color),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    task automatic log_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    // Blend predictor: bounds, optional clip window, then source-over blend
    function automatic pixel_result_t predict_pixel(input logic signed [15:0] x,
                                                    input logic signed [15:0] y,
                                                    input logic [31:0] src,
                                                    input logic [31:0] dst);
        pixel_result_t res;
        int xi, yi, a, d, s, mixed;
        bit hit;
        xi = x;
        yi = y;
        hit = xi >= 0 && xi < int'(model_cfg.frame_width) &&
              yi >= 0 && yi < int'(model_cfg.frame_height);
        // clip edge sums are exact, no 16-bit wrap
        if (hit && model_cfg.clip_on)
            hit = xi >= int'($signed(model_cfg.clip_left)) &&
                  xi <  int'($signed(model_cfg.clip_left)) + int'($signed(model_cfg.clip_width)) &&
                  yi >= int'($signed(model_cfg.clip_top)) &&
                  yi <  int'($signed(model_cfg.clip_top)) + int'($signed(model_cfg.clip_height));
        res.we    = hit;
        res.x     = x;
        res.y     = y;
        res.color = dst;
        if (hit)
        begin
            a = (int'(src[31:24]) * int'(model_cfg.global_alpha)) / int'(FULL_SCALE);
            if (a == int'(FULL_SCALE))
                res.color = src;
            else if (a != 0)
            begin
                res.color = ALPHA_OPAQUE;
                for (int ch = 0; ch < 3; ch++)
                begin
                    d = dst[8*ch +: 8];
                    s = src[8*ch +: 8];
                    // signed division truncates toward zero
                    mixed = d + ((s - d) * a) / int'(FULL_SCALE);
                    res.color[8*ch +: 8] = mixed[7:0];
                end
            end
        end
        return res;
    endfunction

    // One register write; the model copy follows at the same edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_FRAME_WIDTH:  model_cfg.frame_width  = data[12:0];
            CFG_FRAME_HEIGHT: model_cfg.frame_height = data[12:0];
            CFG_CLIP_LEFT:    model_cfg.clip_left    = data;
            CFG_CLIP_TOP:     model_cfg.clip_top     = data;
            CFG_CLIP_WIDTH:   model_cfg.clip_width   = data;
            CFG_CLIP_HEIGHT:  model_cfg.clip_height  = data;
            CFG_CLIP_ON:      model_cfg.clip_on      = data[0];
            CFG_GLOBAL_ALPHA: model_cfg.global_alpha = data[7:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Full register set; unused upper data bits carry random junk
    task automatic apply_settings(input int fw, input int fh, input int left,
                                  input int top, input int wd, input int ht,
                                  input bit on, input logic [7:0] ga);
        cfg_write(CFG_FRAME_WIDTH,  {3'($urandom), 13'(fw)});
        cfg_write(CFG_FRAME_HEIGHT, {3'($urandom), 13'(fh)});
        cfg_write(CFG_CLIP_LEFT,    16'(left));
        cfg_write(CFG_CLIP_TOP,     16'(top));
        cfg_write(CFG_CLIP_WIDTH,   16'(wd));
        cfg_write(CFG_CLIP_HEIGHT,  16'(ht));
        cfg_write(CFG_CLIP_ON,      {15'($urandom), on});
        cfg_write(CFG_GLOBAL_ALPHA, {8'($urandom), ga});
        n_settings++;
    endtask

    // Send one pixel; start stays high after the transfer for back-to-back use
    task automatic send_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic [31:0] src, input logic [31:0] dst);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start        <= 1'b0;
            pixel_x      <= $urandom;
            pixel_y      <= $urandom;
            source_color <= $urandom;
            dest_color   <= $urandom;
            @(posedge clk);
        end
        start        <= 1'b1;
        pixel_x      <= x;
        pixel_y      <= y;
        source_color <= src;
        dest_color   <= dst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_pixel(x, y, src, dst));
        n_pixels++;
    endtask

    // Hold off the sender until every pending pixel has come back
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_source();
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(0, 3))
            0: c[31:24] = 8'h00;
            1: c[31:24] = 8'hFF;
            default: ;
        endcase
        return c;
    endfunction

    // Coordinate on one axis: mostly inside frame and window, else edges/noise
    function automatic logic [15:0] rand_coord(input int frame_size, input int win_lo,
                                               input int win_size, input bit clip,
                                               input bit in_win);
        int lo, hi, v;
        lo = 0;
        hi = frame_size - 1;
        if (clip)
        begin
            if (win_lo > lo)
                lo = win_lo;
            if (win_lo + win_size - 1 < hi)
                hi = win_lo + win_size - 1;
        end
        if (in_win && lo <= hi)
            v = lo + int'($urandom_range(0, hi - lo));
        else
            case ($urandom_range(0, 3))
                0: v = int'($urandom_range(0, 16'hFFFF));
                1: v = $urandom_range(0, 1) ? frame_size - int'($urandom_range(0, 1))
                                            : -int'($urandom_range(0, 1));
                2: v = $urandom_range(0, 1) ? win_lo + win_size - int'($urandom_range(0, 1))
                                            : win_lo - int'($urandom_range(0, 1));
                default: v = int'($urandom_range(0, frame_size + 8)) - 4;
            endcase
        return v[15:0];
    endfunction

    function automatic int pick_frame_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 4096;
            3: return 8191;
            default: return int'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic int pick_window_edge(input int size);
        if ($urandom_range(0, 3) != 0)
            return int'($urandom_range(0, size)) - 8;
        return int'($urandom_range(0, 16'hFFFF)) - 32768;
    endfunction

    function automatic int pick_window_size(input int size);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return -int'($urandom_range(1, 32768));
            2: return int'($urandom_range(0, 16'hFFFF)) - 32768;
            default: return int'($urandom_range(1, size + 8));
        endcase
    endfunction

    function automatic logic [7:0] pick_global_alpha();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return 8'($urandom);
        endcase
    endfunction

    // Reset values: zero frame, so nothing gets written
    task automatic test_reset_state();
        send_pixel(16'sd0, 16'sd0, 32'hFF12_3456, 32'h89AB_CDEF);
    endtask

    // Frame bounds at both ends of each axis and the coordinate extremes
    task automatic test_frame_bounds();
        drain_pipeline();
        apply_settings(8191, 4096, 0, 0, 0, 0, 1'b0, 8'd255);
        send_pixel(16'sd0,     16'sd0,     32'hFF00_00FF, 32'h0000_0000);
        send_pixel(16'sd8190,  16'sd4095,  32'hFFFF_0000, 32'h0000_0000);
        send_pixel(16'sd8191,  16'sd0,     32'hFF00_FF00, 32'h1111_1111);
        send_pixel(16'sd0,     16'sd4096,  32'hFF00_FF00, 32'h2222_2222);
        send_pixel(-16'sd1,    16'sd0,     32'hFFFF_FFFF, 32'h3333_3333);
        send_pixel(16'sd0,     -16'sd1,    32'hFFFF_FFFF, 32'h4444_4444);
        send_pixel(-16'sd32768, 16'sd32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(16'sd32767, -16'sd32768, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Clip window edges, exact edge sums and empty windows
    task automatic test_clip_window();
        drain_pipeline();
        apply_settings(8191, 8191, 100, -20, 50, 30, 1'b1, 8'd255);
        send_pixel(16'sd100, 16'sd0, 32'hFFAA_BBCC, 32'h0102_0304);
        send_pixel(16'sd149, 16'sd9, 32'hFFAA_BBCC, 32'h0102_0304);
        send_pixel(16'sd99,  16'sd0, 32'hFFAA_BBCC, 32'h0102_0304);
        send_pixel(16'sd150, 16'sd0, 32'hFFAA_BBCC, 32'h0102_0304);
        send_pixel(16'sd120, 16'sd10, 32'hFFAA_BBCC, 32'h0102_0304);
        // right edge sum past 16 bits must not wrap
        drain_pipeline();
        apply_settings(8191, 8191, 8000, 0, 32767, 100, 1'b1, 8'd255);
        send_pixel(16'sd8100, 16'sd5, 32'hFF55_6677, 32'h0000_0000);
        // most negative edge sum: window empty
        drain_pipeline();
        apply_settings(8191, 8191, 8000, -32768, 32767, -32768, 1'b1, 8'd255);
        send_pixel(16'sd8100, 16'sd5, 32'hFF55_6677, 32'h0000_0000);
        // clip disabled with a zero-sized window
        drain_pipeline();
        apply_settings(8191, 8191, 0, 0, 0, 0, 1'b0, 8'd255);
        send_pixel(16'sd8100, 16'sd5, 32'hFF55_6677, 32'h0000_0000);
    endtask

    // Effective alpha of zero, full, and in between
    task automatic test_alpha_rules();
        send_pixel(16'sd5, 16'sd5, 32'h0011_2233, 32'h4455_6677);
        send_pixel(16'sd6, 16'sd5, 32'hFFAB_CDEF, 32'h1234_5678);
        send_pixel(16'sd7, 16'sd5, 32'h80FF_00FF, 32'h0000_FF00);
        send_pixel(16'sd8, 16'sd5, 32'h01FF_FFFF, 32'h0000_0000);
        send_pixel(16'sd9, 16'sd5, 32'hFE00_0000, 32'h7FFF_FFFF);
        drain_pipeline();
        apply_settings(8191, 8191, 0, 0, 0, 0, 1'b0, 8'd0);
        send_pixel(16'sd5, 16'sd6, 32'hFF12_3456, 32'h6543_2100);
        drain_pipeline();
        apply_settings(8191, 8191, 0, 0, 0, 0, 1'b0, 8'd128);
        send_pixel(16'sd5, 16'sd7, 32'hFF00_FF80, 32'hC0FF_0080);
        send_pixel(16'sd5, 16'sd8, 32'h01FF_FFFF, 32'h0000_0000);
        drain_pipeline();
        apply_settings(8191, 8191, 0, 0, 0, 0, 1'b0, 8'd1);
        send_pixel(16'sd5, 16'sd9, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // Writes past the register list must leave every register alone
    task automatic test_unused_index();
        drain_pipeline();
        apply_settings(64, 64, 0, 0, 64, 64, 1'b1, 8'd200);
        for (int i = 0; i < 8; i++)
            cfg_write(CFG_IDX_UNUSED + 4'(i), 16'($urandom));
        send_pixel(16'sd10, 16'sd10, 32'h9080_4020, 32'h10E0_30F0);
    endtask

    // Random traffic over several settings and sender gap rates
    task automatic test_random_traffic();
        int pct [3] = '{0, 61, 14};
        logic signed [15:0] x, y;
        bit in_win;
        int fw, fh;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_pipeline();
            if (phase == 0)
                apply_settings(8191, 8191, 0, 0, 32767, 32767, 1'b1, 8'd255);
            else
            begin
                fw = pick_frame_size();
                fh = pick_frame_size();
                apply_settings(fw, fh, pick_window_edge(fw), pick_window_edge(fh),
                               pick_window_size(fw), pick_window_size(fh),
                               $urandom_range(0, 2) != 0, pick_global_alpha());
            end
            gap_pct = pct[phase % 3];
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                in_win = $urandom_range(0, 9) < 7;
                x = rand_coord(model_cfg.frame_width, $signed(model_cfg.clip_left),
                               $signed(model_cfg.clip_width), model_cfg.clip_on, in_win);
                y = rand_coord(model_cfg.frame_height, $signed(model_cfg.clip_top),
                               $signed(model_cfg.clip_height), model_cfg.clip_on, in_win);
                send_pixel(x, y, rand_source(), $urandom);
                if ($urandom_range(0, 199) == 0)
                    drain_pipeline();
            end
        end
        gap_pct = 0;
    endtask

    // Result scoreboard: oldest pending pixel against each done strobe
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            got_result = '{write_enable, out_x, out_y, blended_color};
            if (got_result.we)
                n_written++;
            else
                n_suppressed++;
            if (pending_results.size() == 0)
                log_error("result with no pixel pending");
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result.we !== want_result.we || got_result.x !== want_result.x ||
                    got_result.y !== want_result.y || got_result.color !== want_result.color)
                    log_error($sformatf("exp we=%0b x=%0d y=%0d color=%08h, got we=%0b x=%0d y=%0d color=%08h",
                        want_result.we, want_result.x, want_result.y, want_result.color,
                        got_result.we, got_result.x, got_result.y, got_result.color));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        model_cfg = '0;
        model_cfg.global_alpha = FULL_SCALE;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_frame_bounds();
        test_clip_window();
        test_alpha_rules();
        test_unused_index();
        test_random_traffic();

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            log_error($sformatf("%0d pixels never came back", pending_results.size()));

        $display("Covered %0d pixel transfers (%0d written, %0d suppressed) over %0d settings,",
                 n_pixels, n_written, n_suppressed, n_settings);
        $display("with sender gaps of 0, 14 and 61 percent; %0d mismatches.", n_errors);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
src/cabpw_pkg.sv
src/cabpw_clip.sv
src/cabpw_alpha.sv
src/cabpw_mix.sv
src/clipped_alpha_blend_pixel_write.sv
dv/tb_clipped_alpha_blend_pixel_write.sv
